// ===== src/tls_pkg.sv =====
// Shared types and codes for the typed list scheduler.
// No dependencies; used by every module in src.
package tls_pkg;

  // Table sizes; the output fields are sized for these
  localparam int MAX_OPS     = 16;
  localparam int MAX_DEVICES = 8;

  localparam logic [1:0] ACT_LOAD_OP  = 2'd0;
  localparam logic [1:0] ACT_LOAD_DEV = 2'd1;
  localparam logic [1:0] ACT_START    = 2'd2;
  localparam logic [1:0] ACT_TICK     = 2'd3;

  localparam logic [1:0] EV_STARTED  = 2'd0;
  localparam logic [1:0] EV_FINISHED = 2'd1;
  localparam logic [1:0] EV_STATUS   = 2'd2;

  localparam logic [1:0] CFG_TRANSFER = 2'd0;
  localparam logic [1:0] CFG_OPS      = 2'd1;
  localparam logic [1:0] CFG_DEVS     = 2'd2;

  localparam logic [9:0] TRANSFER_RESET = 10'd10;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture input item, perform load/start
    logic retire_chk; // evaluate retire for op at op_idx
    logic sched_chk;  // evaluate readiness for op at op_idx
    logic dev_chk;    // evaluate device at dev_idx for op at op_idx
    logic tick_end;   // advance time
    logic emit_stat;  // present status item
  } tls_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_tick;
    logic retire_hit;
    logic op_ready;
    logic dev_hit;
    logic all_done;
    logic out_busy;
  } tls_stat_t;

endpackage

// ===== src/tls_ctrl.sv =====
// Sequencing controller for the typed list scheduler.
// Depends on tls_pkg.
module tls_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [$clog2(tls_pkg::MAX_OPS+1)-1:0]     n_ops,
  input  logic [$clog2(tls_pkg::MAX_DEVICES+1)-1:0] n_devs,
  input  tls_pkg::tls_stat_t stat,
  output tls_pkg::tls_cmd_t  cmd,
  output logic [$clog2(tls_pkg::MAX_OPS)-1:0]     op_idx,
  output logic [$clog2(tls_pkg::MAX_DEVICES)-1:0] dev_idx
);
  import tls_pkg::*;

  localparam int OW = $clog2(MAX_OPS+1);
  localparam int DW = $clog2(MAX_DEVICES+1);

  typedef enum logic [2:0] {S_IDLE, S_DECODE, S_RETIRE, S_READY, S_DEV, S_STAT} state_t;
  state_t state;
  logic [OW-1:0] oc;
  logic [DW-1:0] dc;

  assign op_idx  = oc[$clog2(MAX_OPS)-1:0];
  assign dev_idx = dc[$clog2(MAX_DEVICES)-1:0];
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.load       = (state == S_IDLE) && in_valid;
    cmd.retire_chk = (state == S_RETIRE) && (oc < n_ops) && !stat.out_busy;
    cmd.sched_chk  = (state == S_READY) && (oc < n_ops);
    cmd.dev_chk    = (state == S_DEV) && (dc < n_devs) && !stat.out_busy;
    cmd.tick_end   = (state == S_READY) && (oc >= n_ops) && stat.is_tick && !stat.all_done;
    cmd.emit_stat  = (state == S_STAT) && !stat.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      oc <= '0;
      dc <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_DECODE;
        S_DECODE: begin
          oc <= '0;
          state <= stat.is_tick ? S_RETIRE : S_STAT;
        end
        S_RETIRE: begin
          if (oc >= n_ops) begin
            oc <= '0;
            state <= stat.all_done ? S_STAT : S_READY;
          end else if (!stat.out_busy) begin
            oc <= oc + OW'(1);
          end
        end
        S_READY: begin
          if (oc >= n_ops) begin
            state <= S_STAT;
          end else if (stat.op_ready) begin
            dc <= '0;
            state <= S_DEV;
          end else begin
            oc <= oc + OW'(1);
          end
        end
        S_DEV: begin
          if (dc >= n_devs || (cmd.dev_chk && stat.dev_hit)) begin
            oc <= oc + OW'(1);
            state <= S_READY;
          end else if (!stat.out_busy) begin
            dc <= dc + DW'(1);
          end
        end
        S_STAT: if (!stat.out_busy) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/tls_dp.sv =====
// Tables, flags, time and the output register of the typed list scheduler.
// Depends on tls_pkg.
module tls_dp (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data,
  input  logic [1:0]  action,
  input  logic [3:0]  entry_index,
  input  logic [15:0] op_length,
  input  logic [2:0]  kind_code,
  input  logic [15:0] parent_mask,
  input  tls_pkg::tls_cmd_t cmd,
  input  logic [$clog2(tls_pkg::MAX_OPS)-1:0]     op_idx,
  input  logic [$clog2(tls_pkg::MAX_DEVICES)-1:0] dev_idx,
  output tls_pkg::tls_stat_t stat,
  output logic [$clog2(tls_pkg::MAX_OPS+1)-1:0]     n_ops,
  output logic [$clog2(tls_pkg::MAX_DEVICES+1)-1:0] n_devs,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_kind,
  output logic [3:0]  op_id,
  output logic [2:0]  device_id,
  output logic [31:0] event_time,
  output logic        all_done,
  output logic        last
);
  import tls_pkg::*;

  localparam int OW = $clog2(MAX_OPS+1);
  localparam int DW = $clog2(MAX_DEVICES+1);
  localparam int OI = $clog2(MAX_OPS);
  localparam int DI = $clog2(MAX_DEVICES);

  logic [9:0]  transfer_time;
  logic [4:0]  op_count;
  logic [3:0]  device_count;
  logic [1:0]  act;
  logic [15:0] dur_tab [MAX_OPS];
  logic [2:0]  typ_tab [MAX_OPS];
  logic [15:0] par_tab [MAX_OPS];
  logic [31:0] start_tab [MAX_OPS];
  logic [2:0]  bound [MAX_OPS];
  logic [MAX_OPS-1:0]     running, done;
  logic [2:0]  dtype [MAX_DEVICES];
  logic [MAX_DEVICES-1:0] dev_free;
  logic [31:0] now;
  logic [OW-1:0] finished_total;
  logic [MAX_OPS-1:0] inuse;
  logic [MAX_OPS-1:0] par_ext;
  logic [32:0] age_lim;

  assign n_ops  = (32'(op_count) > MAX_OPS) ? OW'(MAX_OPS) : OW'(op_count);
  assign n_devs = (32'(device_count) > MAX_DEVICES) ? DW'(MAX_DEVICES) : DW'(device_count);

  always_comb begin
    for (int k = 0; k < MAX_OPS; k++) inuse[k] = (k < n_ops);
    for (int k = 0; k < MAX_OPS; k++) par_ext[k] = (k < 16) ? par_tab[op_idx][k % 16] : 1'b0;
  end

  assign age_lim = 33'(dur_tab[op_idx]) + 33'(transfer_time);

  assign stat.is_tick    = (act == ACT_TICK);
  assign stat.out_busy   = out_valid && out_stall;
  assign stat.all_done   = (finished_total >= n_ops);
  assign stat.retire_hit = running[op_idx] && !done[op_idx]
                           && (33'(now - start_tab[op_idx]) == age_lim);
  assign stat.op_ready   = !running[op_idx] && !done[op_idx]
                           && ((par_ext & inuse & ~done) == '0);
  assign stat.dev_hit    = dev_free[dev_idx] && (dtype[dev_idx] == typ_tab[op_idx]);

  always_ff @(posedge clk) begin
    if (rst) begin
      transfer_time <= TRANSFER_RESET;
      op_count <= '0;
      device_count <= '0;
      act <= ACT_LOAD_OP;
      running <= '0;
      done <= '0;
      dev_free <= '1;
      now <= '0;
      finished_total <= '0;
      out_valid <= 1'b0;
      for (int k = 0; k < MAX_OPS; k++) begin
        start_tab[k] <= '0;
        bound[k] <= '0;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_TRANSFER: transfer_time <= cfg_data;
          CFG_OPS:      op_count <= cfg_data[4:0];
          CFG_DEVS:     device_count <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        act <= action;
        if (action == ACT_LOAD_OP && 32'(entry_index) < MAX_OPS) begin
          dur_tab[entry_index[OI-1:0]] <= op_length;
          typ_tab[entry_index[OI-1:0]] <= kind_code;
          par_tab[entry_index[OI-1:0]] <= parent_mask;
        end
        if (action == ACT_LOAD_DEV && 32'(entry_index) < MAX_DEVICES)
          dtype[entry_index[DI-1:0]] <= kind_code;
      end
      // start, retire and bind fall in different controller states
      if (cmd.load && action == ACT_START) begin
        running <= '0;
        done <= '0;
        dev_free <= '1;
        now <= '0;
        finished_total <= '0;
      end
      if (cmd.retire_chk && stat.retire_hit) begin
        done[op_idx] <= 1'b1;
        running[op_idx] <= 1'b0;
        if (32'(bound[op_idx]) < MAX_DEVICES) dev_free[bound[op_idx][DI-1:0]] <= 1'b1;
        finished_total <= finished_total + OW'(1);
      end
      if (cmd.dev_chk && stat.dev_hit) begin
        running[op_idx] <= 1'b1;
        dev_free[dev_idx] <= 1'b0;
        start_tab[op_idx] <= now;
        bound[op_idx] <= 3'(dev_idx);
      end
      if (cmd.tick_end && now != '1) now <= now + 32'd1;
      // output register: load a new result or drop a taken one
      if (cmd.retire_chk && stat.retire_hit) begin
        out_valid  <= 1'b1;
        event_kind <= EV_FINISHED;
        op_id      <= 4'(op_idx);
        device_id  <= bound[op_idx];
        event_time <= start_tab[op_idx] + 32'(dur_tab[op_idx]);
        all_done   <= 1'b0;
        last       <= 1'b0;
      end else if (cmd.dev_chk && stat.dev_hit) begin
        out_valid  <= 1'b1;
        event_kind <= EV_STARTED;
        op_id      <= 4'(op_idx);
        device_id  <= 3'(dev_idx);
        event_time <= now;
        all_done   <= 1'b0;
        last       <= 1'b0;
      end else if (cmd.emit_stat) begin
        out_valid  <= 1'b1;
        event_kind <= EV_STATUS;
        op_id      <= '0;
        device_id  <= '0;
        event_time <= now;
        all_done   <= stat.all_done;
        last       <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid  <= 1'b0;
      end
    end
  end
endmodule

// ===== src/typed_list_scheduler_core.sv =====
// Top level of the typed list scheduler: controller plus datapath.
// Depends on tls_pkg, tls_ctrl and tls_dp.
//
// Usage: items arrive on in_valid/in_stall with action, entry_index,
// op_length, kind_code and parent_mask. Load actions update the tables and
// start actions clear run flags and time; each gives one status transfer.
// A tick retires operations whose age reaches duration plus transfer_time
// (finish events, index order); unless every op in use is then done, it
// scans ready operations in index order, binds each to the lowest free
// device of its type (start events) and advances time; then it gives a
// status transfer with last set. Results leave on out_valid/out_stall
// through one output register; while a result is stalled, the retire,
// device and status steps hold until it is taken. The controller scans a
// single entry at a time. One item is in work at a time.
// Reset (rst, synchronous) restores transfer_time 10, zero counts, clears
// run flags, start times, bindings and time and frees all devices; the op
// and device tables stay as they were. Configuration writes (cfg_write,
// cfg_index, cfg_data) are for the user to make only while idle; the block
// itself does not enforce this.
module typed_list_scheduler_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [3:0]  entry_index,
  input  logic [15:0] op_length,
  input  logic [2:0]  kind_code,
  input  logic [15:0] parent_mask,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_kind,
  output logic [3:0]  op_id,
  output logic [2:0]  device_id,
  output logic [31:0] event_time,
  output logic        all_done,
  output logic        last
);
  import tls_pkg::*;

  tls_cmd_t  cmd;
  tls_stat_t stat;
  logic [$clog2(MAX_OPS)-1:0]     op_idx;
  logic [$clog2(MAX_DEVICES)-1:0] dev_idx;
  logic [$clog2(MAX_OPS+1)-1:0]     n_ops;
  logic [$clog2(MAX_DEVICES+1)-1:0] n_devs;

  tls_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .n_ops, .n_devs,
    .stat, .cmd, .op_idx, .dev_idx
  );

  tls_dp u_dp (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .action, .entry_index, .op_length, .kind_code, .parent_mask,
    .cmd, .op_idx, .dev_idx, .stat, .n_ops, .n_devs,
    .out_valid, .out_stall, .event_kind, .op_id, .device_id,
    .event_time, .all_done, .last
  );

  // A stalled result holds still until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable({event_kind, op_id, device_id,
                                                        event_time, all_done, last})))
    else $error("stalled result changed");

  // Status item always closes an input
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((event_kind == EV_STATUS) == last)) else $error("last mismatch");

  // Start and finish events never claim completion
  a_event_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind != EV_STATUS) |-> !all_done) else $error("all_done on event");
endmodule

// ===== tb/tb_typed_list_scheduler_core.sv =====
// Self-checking testbench for typed_list_scheduler_core: table loads, start and
// tick actions, checked event by event against a behavioural schedule model.
// Depends on tls_pkg and the RTL under src.
`timescale 1ns / 1ps

module tb_typed_list_scheduler_core;
  import tls_pkg::*;

  localparam int NOPS      = 16;
  localparam int NDEVS     = 8;
  localparam int ITEM_GOAL = 450;
  localparam int IDLE_LIMIT = 5000;   // cycles without any transfer
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  op;
    logic [2:0]  dev;
    logic [31:0] t;
    logic        done;
    logic        last;
  } sched_ev_t;

  typedef struct {
    logic [1:0]  act;
    logic [3:0]  idx;
    logic [15:0] len;
    logic [2:0]  kind;
    logic [15:0] mask;
    bit          typed;   // expected status written in below
    logic [31:0] exp_t;
    logic        exp_done;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = CFG_TRANSFER;
  logic [9:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = ACT_TICK;
  logic [3:0]  entry_index = '0;
  logic [15:0] op_length = '0;
  logic [2:0]  kind_code = '0;
  logic [15:0] parent_mask = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  event_kind;
  logic [3:0]  op_id;
  logic [2:0]  device_id;
  logic [31:0] event_time;
  logic        all_done;
  logic        last;

  typed_list_scheduler_core dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .action, .entry_index, .op_length, .kind_code,
    .parent_mask, .out_valid, .out_stall, .event_kind, .op_id, .device_id,
    .event_time, .all_done, .last
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Schedule model: own copy of tables, flags, time and registers
  // ---------------------------------------------------------------------------
  logic [9:0]  m_transfer;
  logic [4:0]  m_ops;
  logic [3:0]  m_devs;
  logic [15:0] m_dur   [NOPS];
  logic [2:0]  m_otype [NOPS];
  logic [15:0] m_par   [NOPS];
  logic [31:0] m_start [NOPS];
  logic [2:0]  m_bound [NOPS];
  logic [15:0] m_running, m_done;
  logic [2:0]  m_dtype [NDEVS];
  logic [7:0]  m_free;
  logic [31:0] m_now;
  logic [4:0]  m_finished;
  bit          m_all;        // all_done of the latest status

  sched_ev_t pending_events[$];
  int        fail_count = 0;
  int        items_sent = 0;
  int        idle_cycles = 0;
  bit        hold_req = 1'b0;

  task automatic model_reset();
    m_transfer = TRANSFER_RESET;
    m_ops = '0;
    m_devs = '0;
    for (int i = 0; i < NOPS; i++) begin
      m_start[i] = '0;
      m_bound[i] = '0;
    end
    m_running = '0;
    m_done = '0;
    m_free = '1;
    m_now = '0;
    m_finished = '0;
    m_all = 1'b1;
  endtask

  task automatic model_config(input logic [1:0] ix, input logic [9:0] val);
    case (ix)
      CFG_TRANSFER: m_transfer = val;
      CFG_OPS:      m_ops = val[4:0];
      CFG_DEVS:     m_devs = val[3:0];
      default: ;
    endcase
  endtask

  function automatic sched_ev_t mk_ev(logic [1:0] k, int op, int dev,
                                      logic [31:0] t, logic d);
    sched_ev_t e;
    e.kind = k;
    e.op = op[3:0];
    e.dev = dev[2:0];
    e.t = t;
    e.done = d;
    e.last = 1'b0;
    return e;
  endfunction

  // Works out the events one transfer causes and advances the model.
  task automatic schedule_step(input logic [1:0] act, input logic [3:0] idx,
                               input logic [15:0] len, input logic [2:0] kind,
                               input logic [15:0] mask, ref sched_ev_t evs[$]);
    int nops, ndev;
    logic [15:0] inuse;
    logic [31:0] busy_for;
    sched_ev_t st;
    nops = (m_ops > NOPS) ? NOPS : m_ops;
    ndev = (m_devs > NDEVS) ? NDEVS : m_devs;
    inuse = (nops >= 16) ? 16'hFFFF : 16'((1 << nops) - 1);
    evs = {};
    case (act)
      ACT_LOAD_OP: begin
        m_dur[idx] = len;
        m_otype[idx] = kind;
        m_par[idx] = mask;
      end
      ACT_LOAD_DEV: begin
        if (idx < NDEVS) m_dtype[idx[2:0]] = kind;
      end
      ACT_START: begin
        m_running = '0;
        m_done = '0;
        m_finished = '0;
        m_free = '1;
        m_now = '0;
      end
      default: begin
        // retire pass
        for (int i = 0; i < nops; i++) begin
          if (m_done[i] || !m_running[i]) continue;
          busy_for = 32'(m_dur[i]) + 32'(m_transfer);
          if (m_now - m_start[i] == busy_for) begin
            m_done[i] = 1'b1;
            m_running[i] = 1'b0;
            m_free[m_bound[i]] = 1'b1;
            m_finished++;
            evs = {evs, mk_ev(EV_FINISHED, i, m_bound[i],
                              m_start[i] + 32'(m_dur[i]), 1'b0)};
          end
        end
        // scan pass, skipped once everything in use is done
        if (m_finished < nops) begin
          for (int i = 0; i < nops; i++) begin
            if (m_running[i] || m_done[i]) continue;
            if ((m_par[i] & inuse & ~m_done) != 0) continue;
            for (int j = 0; j < ndev; j++) begin
              if (m_free[j] && m_dtype[j] == m_otype[i]) begin
                m_bound[i] = j[2:0];
                m_start[i] = m_now;
                m_running[i] = 1'b1;
                m_free[j] = 1'b0;
                evs = {evs, mk_ev(EV_STARTED, i, j, m_now, 1'b0)};
                break;
              end
            end
          end
          if (m_now != 32'hFFFF_FFFF) m_now++;
        end
      end
    endcase
    m_all = (m_finished >= nops);
    st = mk_ev(EV_STATUS, 0, 0, m_now, m_all);
    st.last = 1'b1;
    evs = {evs, st};
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps; drives at the falling edge
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_item(input logic [1:0] act, input logic [3:0] idx,
                           input logic [15:0] len, input logic [2:0] kind,
                           input logic [15:0] mask, input bit typed = 1'b0,
                           input logic [31:0] exp_t = '0,
                           input logic exp_done = 1'b0);
    sched_ev_t evs[$];
    sched_ev_t st;
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    action = act;
    entry_index = idx;
    op_length = len;
    kind_code = kind;
    parent_mask = mask;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    schedule_step(act, idx, len, kind, mask, evs);
    if (typed) begin
      // hand-written status for the obvious rows
      st = mk_ev(EV_STATUS, 0, 0, exp_t, exp_done);
      st.last = 1'b1;
      pending_events = {pending_events, st};
    end else begin
      pending_events = {pending_events, evs};
    end
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    burst_left = 0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] ix, input logic [9:0] val);
    cfg_write = 1'b1;
    cfg_index = ix;
    cfg_data = val;
    model_config(ix, val);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: own stall pattern, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  int stall_mode = 0;

  always @(negedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall = 1'b0;
        1: out_stall = ($urandom_range(0, 3) == 0);
        2: out_stall = ($urandom_range(0, 1) == 0);
        default: out_stall = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result check, sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sched_ev_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $error("unexpected result transfer: kind %0d op %0d time %0d",
               event_kind, op_id, event_time);
        fail_count++;
      end else begin
        want = pending_events.pop_front();
        if (event_kind !== want.kind) begin
          $error("event_kind: expected %0d, got %0d", want.kind, event_kind);
          fail_count++;
        end
        if (op_id !== want.op) begin
          $error("op_id: expected %0d, got %0d", want.op, op_id);
          fail_count++;
        end
        if (device_id !== want.dev) begin
          $error("device_id: expected %0d, got %0d", want.dev, device_id);
          fail_count++;
        end
        if (event_time !== want.t) begin
          $error("event_time: expected %0d, got %0d", want.t, event_time);
          fail_count++;
        end
        if (all_done !== want.done) begin
          $error("all_done: expected %0d, got %0d", want.done, all_done);
          fail_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: no transfer on either side for too long ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Directed rows run straight after reset: no ops or devices in use, so every
  // status reads time 0 with all_done set. Loads at the extremes of each field.
  stim_row_t directed[] = '{
    '{ACT_TICK,     4'd0,  16'h0000, 3'd0, 16'h0000, 1'b1, 32'd0, 1'b1},
    '{ACT_START,    4'd0,  16'h0000, 3'd0, 16'h0000, 1'b1, 32'd0, 1'b1},
    '{ACT_LOAD_OP,  4'd0,  16'h0000, 3'd0, 16'h0000, 1'b1, 32'd0, 1'b1},
    '{ACT_LOAD_OP,  4'd15, 16'hFFFF, 3'd7, 16'hFFFF, 1'b1, 32'd0, 1'b1},
    '{ACT_LOAD_DEV, 4'd15, 16'h0000, 3'd7, 16'h0000, 1'b1, 32'd0, 1'b1},
    '{ACT_LOAD_DEV, 4'd7,  16'h0000, 3'd7, 16'h0000, 1'b1, 32'd0, 1'b1},
    '{ACT_LOAD_DEV, 4'd0,  16'h0000, 3'd0, 16'h0000, 1'b1, 32'd0, 1'b1},
    '{ACT_TICK,     4'd15, 16'hFFFF, 3'd7, 16'hFFFF, 1'b1, 32'd0, 1'b1},
    '{ACT_LOAD_OP,  4'd1,  16'h0003, 3'd4, 16'h0001, 1'b0, 32'd0, 1'b0},
    '{ACT_START,    4'd0,  16'h0000, 3'd0, 16'h0000, 1'b0, 32'd0, 1'b0}
  };

  function automatic logic [2:0] pick_kind();
    return ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                       : 3'($urandom_range(0, 4));
  endfunction

  // Random content for an operation entry: mostly short jobs whose parents
  // sit below it; now and then a long job or an arbitrary (maybe self) mask.
  task automatic load_op(input int i);
    logic [15:0] len, mask;
    len = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 5));
    if ($urandom_range(0, 9) == 0)
      mask = 16'($urandom());
    else
      mask = 16'($urandom() & $urandom()) & 16'((1 << i) - 1);
    send_item(ACT_LOAD_OP, i[3:0], len, pick_kind(), mask);
  endtask

  initial begin
    int phase;
    int ticks;
    logic [9:0] tt, nops, ndev;
    model_reset();
    repeat (5) @(negedge clk);
    rst = 1'b0;

    foreach (directed[r])
      send_item(directed[r].act, directed[r].idx, directed[r].len, directed[r].kind,
                directed[r].mask, directed[r].typed, directed[r].exp_t,
                directed[r].exp_done);

    // every entry gets content before any count lets a tick read it
    for (int i = 0; i < NOPS; i++) load_op(i);
    for (int j = 0; j < NDEVS; j++)
      send_item(ACT_LOAD_DEV, j[3:0], 16'($urandom()), 3'(j % 5), 16'($urandom()));

    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      drain();
      case (phase)
        0: begin tt = 10'd0;    nops = 10'd16; ndev = 10'd8;  end
        1: begin tt = 10'd1023; nops = 10'd31; ndev = 10'd15; end
        2: begin tt = 10'd2;    nops = 10'd0;  ndev = 10'd0;  end
        default: begin
          tt   = ($urandom_range(0, 5) == 0) ? 10'($urandom_range(0, 1023))
                                             : 10'($urandom_range(0, 3));
          nops = 10'($urandom_range(1, 18));
          ndev = 10'($urandom_range(1, 9));
        end
      endcase
      write_cfg(CFG_TRANSFER, tt);
      write_cfg(CFG_OPS, nops);
      write_cfg(CFG_DEVS, ndev);

      // most phases reload and restart; some carry on with the old run so
      // changed counts act on flags left over from it
      if (phase < 3 || $urandom_range(0, 3) != 0) begin
        for (int i = 0; i < NOPS; i++) load_op(i);
        for (int j = 0; j < NDEVS; j++)
          send_item(ACT_LOAD_DEV, j[3:0], 16'($urandom()), pick_kind(),
                    16'($urandom()));
        send_item(ACT_LOAD_DEV, 4'($urandom_range(8, 15)), 16'($urandom()),
                  3'($urandom()), 16'($urandom()));
        send_item(ACT_START, 4'($urandom()), 16'($urandom()), 3'($urandom()),
                  16'($urandom()));
      end

      if (phase == 3) hold_req = 1'b1;   // receiver backs up, block fills

      ticks = 0;
      while (ticks < 40 && !(m_all && ticks > 2)) begin
        if ($urandom_range(0, 11) == 0)
          send_item(ACT_LOAD_DEV, 4'($urandom()), 16'($urandom()), pick_kind(),
                    16'($urandom()));
        else begin
          send_item(ACT_TICK, 4'($urandom()), 16'($urandom()), 3'($urandom()),
                    16'($urandom()));
          ticks++;
        end
      end
      phase++;
    end

    drain();
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
